FILE: rtl/core/rsup_pkg.sv
// Shared types and constants for the radix string to unsigned parser.
// Holds the character codes, radix limits and the token passed between
// the front end, the token queue and the back end. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsup_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int CHAR_W          = 21;
  localparam int CFG_W           = 8;
  localparam int RADIX_W         = 6;
  localparam int DIGIT_W         = 6;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CFG_W-1:0]   RADIX_RESET   = 8'd10;
  localparam logic [CFG_W-1:0]   RADIX_MIN     = 8'd2;
  localparam logic [CFG_W-1:0]   RADIX_MAX     = 8'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 6'd10;
  localparam logic [DIGIT_W-1:0] LETTER_BASE   = 6'd10;

  localparam logic [CHAR_W-1:0] CH_NUL   = 21'h000000;
  localparam logic [CHAR_W-1:0] CH_TAB   = 21'h000009;
  localparam logic [CHAR_W-1:0] CH_SPACE = 21'h000020;
  localparam logic [CHAR_W-1:0] CH_0     = 21'h000030;
  localparam logic [CHAR_W-1:0] CH_9     = 21'h000039;
  localparam logic [CHAR_W-1:0] CH_UA    = 21'h000041;
  localparam logic [CHAR_W-1:0] CH_UZ    = 21'h00005A;
  localparam logic [CHAR_W-1:0] CH_LA    = 21'h000061;
  localparam logic [CHAR_W-1:0] CH_LZ    = 21'h00007A;

  typedef enum logic [1:0] {
    TOK_DIGIT = 2'd0,
    TOK_BLANK = 2'd1,
    TOK_STRAY = 2'd2,
    TOK_END   = 2'd3
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t            kind;
    logic [DIGIT_W-1:0]   digit;
    logic [RADIX_W-1:0]   radix;
  } tok_t;

endpackage

`default_nettype wire

FILE: rtl/core/rsup_front.sv
// Front end: holds the radix register and classifies each character.
// Produces rsup_pkg::tok_t tokens for the token queue.
`timescale 1ns / 1ps
`default_nettype none

module rsup_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           radix_wr_en,
  input  wire logic [rsup_pkg::CFG_W-1:0]     radix_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [rsup_pkg::CHAR_W-1:0]    char_code,
  input  wire logic                           q_full,
  output logic                                q_push,
  output rsup_pkg::tok_t                      q_tok
);

  logic [rsup_pkg::CFG_W-1:0]   radix;
  logic [rsup_pkg::RADIX_W-1:0] eff_radix;
  logic                         is_digit;
  logic                         is_blank;
  logic [rsup_pkg::DIGIT_W-1:0] dval;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rsup_pkg::RADIX_RESET;
    end else if (radix_wr_en) begin
      radix <= radix_wr_data;
    end
  end

  always_comb begin
    if (radix < rsup_pkg::RADIX_MIN || radix > rsup_pkg::RADIX_MAX) begin
      eff_radix = rsup_pkg::RADIX_DEFAULT;
    end else begin
      eff_radix = radix[rsup_pkg::RADIX_W-1:0];
    end
  end

  always_comb begin
    is_digit = 1'b1;
    dval     = '0;
    if (char_code >= rsup_pkg::CH_0 && char_code <= rsup_pkg::CH_9) begin
      dval = rsup_pkg::DIGIT_W'(char_code - rsup_pkg::CH_0);
    end else if (char_code >= rsup_pkg::CH_LA && char_code <= rsup_pkg::CH_LZ) begin
      dval = rsup_pkg::DIGIT_W'(char_code - rsup_pkg::CH_LA) + rsup_pkg::LETTER_BASE;
    end else if (char_code >= rsup_pkg::CH_UA && char_code <= rsup_pkg::CH_UZ) begin
      dval = rsup_pkg::DIGIT_W'(char_code - rsup_pkg::CH_UA) + rsup_pkg::LETTER_BASE;
    end else begin
      is_digit = 1'b0;
    end
  end

  assign is_blank = (char_code == rsup_pkg::CH_SPACE) || (char_code == rsup_pkg::CH_TAB);

  // A digit that is not below the radix fails in every phase, exactly like
  // a stray character, so it is classified as one here.
  always_comb begin
    q_tok.digit = dval;
    q_tok.radix = eff_radix;
    if (char_code == rsup_pkg::CH_NUL) begin
      q_tok.kind = rsup_pkg::TOK_END;
    end else if (is_digit && dval < rsup_pkg::DIGIT_W'(eff_radix)) begin
      q_tok.kind = rsup_pkg::TOK_DIGIT;
    end else if (is_blank) begin
      q_tok.kind = rsup_pkg::TOK_BLANK;
    end else begin
      q_tok.kind = rsup_pkg::TOK_STRAY;
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

FILE: rtl/core/rsup_queue.sv
// Small token queue between the front end and the back end.
// Stores rsup_pkg::tok_t entries; depth is rsup_pkg::QUEUE_DEPTH.
`timescale 1ns / 1ps
`default_nettype none

module rsup_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire rsup_pkg::tok_t push_tok,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output rsup_pkg::tok_t      head_tok
);

  localparam int PTR_W = (rsup_pkg::QUEUE_DEPTH > 1) ? $clog2(rsup_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(rsup_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(rsup_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(rsup_pkg::QUEUE_DEPTH - 1);

  rsup_pkg::tok_t   entries [rsup_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == DEPTH_C);
  assign not_empty = (count != '0);
  assign head_tok  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_C) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_C) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("token queue count exceeds its depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("token pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("token popped from an empty queue");

endmodule

`default_nettype wire

FILE: rtl/core/rsup_back.sv
// Back end: runs the parse phase machine, the radix multiply-add with exact
// overflow check, and the result register. Uses rsup_pkg tokens.
`timescale 1ns / 1ps
`default_nettype none

module rsup_back #(
  parameter int VALUE_WIDTH = rsup_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_not_empty,
  input  wire rsup_pkg::tok_t          q_tok,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [VALUE_WIDTH-1:0]       parsed_value,
  output logic                         parse_ok
);

  localparam int PW = VALUE_WIDTH + rsup_pkg::RADIX_W;

  typedef enum logic [3:0] {
    PH_LEAD   = 4'b0001,
    PH_DIGITS = 4'b0010,
    PH_TRAIL  = 4'b0100,
    PH_FAIL   = 4'b1000
  } phase_t;

  phase_t                  phase;
  phase_t                  phase_next;
  logic [VALUE_WIDTH-1:0]  acc;
  logic [VALUE_WIDTH-1:0]  acc_next;
  logic                    out_valid_next;
  logic                    load_result;
  logic [PW-1:0]           mac;
  logic                    fits;

  assign mac  = PW'(acc) * PW'(q_tok.radix) + PW'(q_tok.digit);
  assign fits = (mac[PW-1:VALUE_WIDTH] == '0);

  // A string end may only leave the queue when the result register is free.
  assign q_pop = q_not_empty &&
                 ((q_tok.kind != rsup_pkg::TOK_END) || !out_valid || out_ready);
  assign load_result = q_pop && (q_tok.kind == rsup_pkg::TOK_END);

  always_comb begin
    phase_next     = phase;
    acc_next       = acc;
    out_valid_next = out_valid && !out_ready;
    if (q_pop) begin
      case (q_tok.kind)
        rsup_pkg::TOK_END: begin
          phase_next     = PH_LEAD;
          acc_next       = '0;
          out_valid_next = 1'b1;
        end
        rsup_pkg::TOK_DIGIT: begin
          unique case (phase) inside
            PH_LEAD, PH_DIGITS: begin
              if (fits) begin
                phase_next = PH_DIGITS;
                acc_next   = mac[VALUE_WIDTH-1:0];
              end else begin
                phase_next = PH_FAIL;
              end
            end
            PH_TRAIL: phase_next = PH_FAIL;
            PH_FAIL:  phase_next = PH_FAIL;
            default:  phase_next = PH_FAIL;
          endcase
        end
        rsup_pkg::TOK_BLANK: begin
          if (phase == PH_DIGITS) begin
            phase_next = PH_TRAIL;
          end
        end
        default: begin
          phase_next = PH_FAIL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEAD;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      acc       <= acc_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      parse_ok     <= (phase == PH_DIGITS) || (phase == PH_TRAIL);
      parsed_value <= ((phase == PH_DIGITS) || (phase == PH_TRAIL)) ? acc : '0;
    end
  end

  a_lead_acc_zero: assert property (@(posedge clk) disable iff (rst)
      (phase == PH_LEAD) |-> (acc == '0))
    else $error("accumulator not zero in the leading blank phase");
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
      load_result |=> out_valid)
    else $error("string end did not produce a result");
  a_fail_value_zero: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !parse_ok) |-> (parsed_value == '0))
    else $error("failed parse carries a nonzero value");
  a_fail_holds_acc: assert property (@(posedge clk) disable iff (rst)
      (phase == PH_FAIL && !load_result) |=> $stable(acc))
    else $error("accumulator changed after a failure");

endmodule

`default_nettype wire

FILE: rtl/core/radix_string_to_unsigned_parser_unit.sv
// Top level of the radix string to unsigned parser.
// Connects rsup_front, rsup_queue and rsup_back; uses rsup_pkg.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid / in_ready    char_code
//   out       output     out_valid / out_ready  parsed_value, parse_ok
//   radix     input      radix_wr_en            radix_wr_data
//
// One character is taken per cycle while the token queue is not full; a character
// passes through the token queue to the back end, and the result of a NUL is offered
// on the cycle after the NUL leaves the queue.
// The combinational multiply-add by the radix sets the cycle time.
// Reset (rst, synchronous) clears the phase, accumulator, queue and result
// valid, and sets the radix to 10. A stalled result holds only a NUL at the
// queue head; the front keeps taking characters until the two-entry queue fills.
`timescale 1ns / 1ps
`default_nettype none

module radix_string_to_unsigned_parser_unit #(
  parameter int VALUE_WIDTH = rsup_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         radix_wr_en,
  input  wire logic [rsup_pkg::CFG_W-1:0]   radix_wr_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [rsup_pkg::CHAR_W-1:0]  char_code,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [VALUE_WIDTH-1:0]            parsed_value,
  output logic                              parse_ok
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_not_empty;
  rsup_pkg::tok_t push_tok;
  rsup_pkg::tok_t head_tok;

  rsup_front u_front (
    .clk           (clk),
    .rst           (rst),
    .radix_wr_en   (radix_wr_en),
    .radix_wr_data (radix_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_code     (char_code),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_tok         (push_tok)
  );

  rsup_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_tok  (push_tok),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_tok  (head_tok)
  );

  rsup_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_tok        (head_tok),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parsed_value (parsed_value),
    .parse_ok     (parse_ok)
  );

endmodule

`default_nettype wire

FILE: dv/radix_string_to_unsigned_parser_unit_tb.sv
// Self-checking testbench for radix_string_to_unsigned_parser_unit.
// Streams NUL-terminated character strings through the block under several radix
// settings and checks every parsed result; depends on the RTL and rsup_pkg only.
`timescale 1ns / 1ps
module radix_string_to_unsigned_parser_unit_tb;

  localparam int CHAR_W = rsup_pkg::CHAR_W;
  localparam int CFG_W  = rsup_pkg::CFG_W;
  localparam int VW     = rsup_pkg::VALUE_WIDTH_DEF;
  localparam logic [CFG_W-1:0] RADIX_RESET = rsup_pkg::RADIX_RESET;
  localparam logic [CFG_W-1:0] RADIX_MIN   = rsup_pkg::RADIX_MIN;
  localparam logic [CFG_W-1:0] RADIX_MAX   = rsup_pkg::RADIX_MAX;
  localparam logic [rsup_pkg::RADIX_W-1:0] RADIX_DEFAULT = rsup_pkg::RADIX_DEFAULT;
  localparam logic [rsup_pkg::DIGIT_W-1:0] LETTER_BASE   = rsup_pkg::LETTER_BASE;
  localparam logic [CHAR_W-1:0] CH_NUL   = rsup_pkg::CH_NUL;
  localparam logic [CHAR_W-1:0] CH_TAB   = rsup_pkg::CH_TAB;
  localparam logic [CHAR_W-1:0] CH_SPACE = rsup_pkg::CH_SPACE;
  localparam logic [CHAR_W-1:0] CH_0     = rsup_pkg::CH_0;
  localparam logic [CHAR_W-1:0] CH_9     = rsup_pkg::CH_9;
  localparam logic [CHAR_W-1:0] CH_UA    = rsup_pkg::CH_UA;
  localparam logic [CHAR_W-1:0] CH_UZ    = rsup_pkg::CH_UZ;
  localparam logic [CHAR_W-1:0] CH_LA    = rsup_pkg::CH_LA;
  localparam logic [CHAR_W-1:0] CH_LZ    = rsup_pkg::CH_LZ;

  localparam logic [VW-1:0] VALUE_MAX = '1;
  localparam int unsigned TOP_DIGIT = 35;
  localparam logic [CHAR_W-1:0] CH_MINUS = 21'h00002D;
  localparam logic [CHAR_W-1:0] CH_TOP = '1;
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_CHARS = 30;
  localparam int PHASE_STRINGS = 5;

  typedef enum logic [1:0] {
    SCAN_LEAD   = 2'd0,
    SCAN_DIGITS = 2'd1,
    SCAN_TRAIL  = 2'd2,
    SCAN_FAIL   = 2'd3
  } scan_state_t;

  typedef struct packed {
    logic [VW-1:0] value;
    logic          ok;
  } parse_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              radix_wr_en = 1'b0;
  logic [CFG_W-1:0]  radix_wr_data = RADIX_RESET;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CHAR_W-1:0] char_code = CH_NUL;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [VW-1:0]     parsed_value;
  logic              parse_ok;

  // Predictor state and the radix it believes is programmed.
  logic [CFG_W-1:0] cur_radix = RADIX_RESET;
  scan_state_t      scan_st = SCAN_LEAD;
  logic [VW-1:0]    acc = '0;

  logic [CHAR_W-1:0] char_fifo[$];
  parse_result_t     expected_results[$];
  int                chars_queued = 0;
  int                chars_taken = 0;
  int                strings_queued = 0;
  int                mismatches = 0;

  logic idle_on = 1'b0;
  logic hold_sink_req = 1'b0;
  logic hold_done = 1'b0;
  int   feed_gap = 0;
  int   sink_gap = 0;
  int   quiet_cycles = 0;

  radix_string_to_unsigned_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .radix_wr_en  (radix_wr_en),
    .radix_wr_data(radix_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .parsed_value (parsed_value),
    .parse_ok     (parse_ok)
  );

  always #4 clk = ~clk;

  function automatic int unsigned eff_radix(input logic [CFG_W-1:0] r);
    if (r < RADIX_MIN || r > RADIX_MAX) return 32'(RADIX_DEFAULT);
    return 32'(r);
  endfunction

  task automatic predict_char(input logic [CHAR_W-1:0] c);
    parse_result_t res;
    logic [VW-1:0] d;
    logic [VW-1:0] r;
    logic          is_digit;
    logic          is_blank;
    is_digit = 1'b1;
    d = '0;
    if (c >= CH_0 && c <= CH_9) d = VW'(c - CH_0);
    else if (c >= CH_LA && c <= CH_LZ) d = VW'(c - CH_LA) + VW'(LETTER_BASE);
    else if (c >= CH_UA && c <= CH_UZ) d = VW'(c - CH_UA) + VW'(LETTER_BASE);
    else is_digit = 1'b0;
    is_blank = (c == CH_SPACE || c == CH_TAB);
    r = VW'(eff_radix(cur_radix));
    if (c == CH_NUL) begin
      res.ok = (scan_st == SCAN_DIGITS || scan_st == SCAN_TRAIL);
      res.value = res.ok ? acc : '0;
      expected_results.push_back(res);
      scan_st = SCAN_LEAD;
      acc = '0;
    end else begin
      case (scan_st)
        SCAN_LEAD, SCAN_DIGITS: begin
          if (is_digit) begin
            // Exact overflow test, done before the multiply-add.
            if (d >= r || acc > (VALUE_MAX - d) / r) begin
              scan_st = SCAN_FAIL;
            end else begin
              acc = acc * r + d;
              scan_st = SCAN_DIGITS;
            end
          end else if (is_blank) begin
            if (scan_st == SCAN_DIGITS) scan_st = SCAN_TRAIL;
          end else begin
            scan_st = SCAN_FAIL;
          end
        end
        SCAN_TRAIL: begin
          if (!is_blank) scan_st = SCAN_FAIL;
        end
        default: scan_st = SCAN_FAIL;
      endcase
    end
  endtask

  task automatic push_char(input logic [CHAR_W-1:0] c);
    char_fifo.push_back(c);
    chars_queued++;
  endtask

  task automatic end_string();
    push_char(CH_NUL);
    strings_queued++;
  endtask

  task automatic push_blanks(input int unsigned n);
    repeat (n) push_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input int unsigned d);
    if (d < LETTER_BASE) return CHAR_W'(CH_0 + d);
    if ($urandom_range(0, 1)) return CHAR_W'(CH_UA + d - LETTER_BASE);
    return CHAR_W'(CH_LA + d - LETTER_BASE);
  endfunction

  task automatic push_number(input logic [VW-1:0] v, input int unsigned r);
    int unsigned   digs[$];
    logic [VW-1:0] rest;
    rest = v;
    do begin
      digs.push_front(32'(rest % r));
      rest = rest / r;
    end while (rest != 0);
    foreach (digs[i]) push_char(digit_char(digs[i]));
  endtask

  // Mostly short values so that strings stay short, with a few wide ones.
  function automatic logic [VW-1:0] random_value();
    int unsigned   w;
    logic [VW-1:0] v;
    w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, VW) : $urandom_range(1, 16);
    v = {$urandom, $urandom};
    if (w < VW) v = v & ~(VALUE_MAX << w);
    return v;
  endfunction

  // Codes just outside the digit, letter and blank codes, or anything above ASCII.
  function automatic logic [CHAR_W-1:0] random_stray();
    case ($urandom_range(0, 9))
      0: return CH_0 - 21'd1;
      1: return CH_9 + 21'd1;
      2: return CH_UA - 21'd1;
      3: return CH_UZ + 21'd1;
      4: return CH_LA - 21'd1;
      5: return CH_LZ + 21'd1;
      6: return CH_TAB + 21'd1;
      7: return CH_SPACE - 21'd1;
      default: return CHAR_W'($urandom_range(21'h80, CH_TOP));
    endcase
  endfunction

  task automatic queue_directed();
    int unsigned r;
    r = eff_radix(cur_radix);
    end_string();
    push_blanks(2);
    end_string();
    push_char(CH_TAB);
    push_char(digit_char(7));
    push_char(CH_SPACE);
    push_char(CH_TAB);
    end_string();
    // A digit after a trailing blank fails the parse.
    push_char(digit_char(1));
    push_char(CH_SPACE);
    push_char(digit_char(2));
    end_string();
    push_char(CH_LA);
    end_string();
    push_char(CH_UZ);
    end_string();
    // The digit after the failure must be ignored.
    push_char(CH_MINUS);
    push_char(digit_char(5));
    end_string();
    push_char(CH_TOP);
    end_string();
    push_char(21'h80);
    push_char(CH_9);
    end_string();
    push_number(VALUE_MAX, r);
    end_string();
    push_number(VALUE_MAX, r);
    push_char(CH_0);
    end_string();
    push_char(CH_0);
    end_string();
  endtask

  task automatic queue_random_string();
    int unsigned r;
    int unsigned pick;
    r = eff_radix(cur_radix);
    pick = $urandom_range(0, 19);
    if (pick <= 9) begin
      push_blanks($urandom_range(0, 2));
      push_number((pick == 9) ? VALUE_MAX : random_value(), r);
      push_blanks($urandom_range(0, 2));
    end else begin
      case (pick)
        10: begin
          // Right at the overflow boundary: the last digit decides.
          push_number(VALUE_MAX / r, r);
          push_char(digit_char($urandom_range(0, r - 1)));
          push_blanks($urandom_range(0, 1));
        end
        11: begin
          push_number(VALUE_MAX, r);
          push_char(digit_char($urandom_range(0, r - 1)));
        end
        12: begin
          push_number(random_value(), r);
          if (r <= TOP_DIGIT) push_char(digit_char($urandom_range(r, TOP_DIGIT)));
          else push_char(random_stray());
        end
        13: begin
          push_number(random_value(), r);
          push_char(random_stray());
          push_number(random_value(), r);
        end
        14: begin
          push_number(random_value(), r);
          push_blanks($urandom_range(1, 2));
          push_number(random_value(), r);
        end
        15: push_blanks($urandom_range(0, 3));
        16, 17: begin
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 1)) push_char(CHAR_W'($urandom_range(1, CH_TOP)));
            else push_char(digit_char($urandom_range(0, TOP_DIGIT)));
          end
        end
        18: begin
          push_blanks($urandom_range(0, 2));
          repeat ($urandom_range(1, 3)) push_char(CH_0);
          push_number(random_value(), r);
        end
        default: begin
          push_char(random_stray());
          push_number(random_value(), r);
        end
      endcase
    end
    end_string();
  endtask

  // Programs the radix while the block is idle, sends one batch of strings and
  // holds the sender until the last result of the batch is back.
  task automatic run_phase(input logic [CFG_W-1:0] r, input bit with_idle,
                           input bit directed, input bit long_hold);
    int start_chars;
    int start_strings;
    @(posedge clk);
    radix_wr_en <= 1'b1;
    radix_wr_data <= r;
    idle_on <= with_idle;
    cur_radix = r;
    @(posedge clk);
    radix_wr_en <= 1'b0;
    if (long_hold) hold_sink_req <= 1'b1;
    if (directed) queue_directed();
    start_chars = chars_queued;
    start_strings = strings_queued;
    while (chars_queued - start_chars < PHASE_CHARS ||
           strings_queued - start_strings < PHASE_STRINGS) begin
      queue_random_string();
    end
    while (chars_taken != chars_queued || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Character driver; a request is predicted at the edge where it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      feed_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_char(char_code);
        chars_taken++;
      end
      if (!in_valid || in_ready) begin
        if (feed_gap != 0) begin
          feed_gap <= feed_gap - 1;
          in_valid <= 1'b0;
        end else if (char_fifo.size() != 0) begin
          if (idle_on && $urandom_range(0, 11) == 0) begin
            feed_gap <= $urandom_range(0, 17);
            in_valid <= 1'b0;
          end else begin
            char_code <= char_fifo.pop_front();
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin : check_results
    parse_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: value %0h ok %0b", parsed_value, parse_ok);
          end
        end else begin
          want = expected_results.pop_front();
          if (parsed_value !== want.value || parse_ok !== want.ok) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected value %0h ok %0b, got value %0h ok %0b",
                       want.value, want.ok, parsed_value, parse_ok);
            end
          end
        end
      end
      if (hold_sink_req && !hold_done) begin
        hold_done <= 1'b1;
        sink_gap <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        sink_gap <= $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    run_phase(RADIX_RESET, 1'b1, 1'b1, 1'b0);
    run_phase(RADIX_MAX, 1'b1, 1'b0, 1'b0);
    run_phase(RADIX_MIN, 1'b1, 1'b0, 1'b0);
    run_phase(8'd16, 1'b1, 1'b0, 1'b1);
    run_phase(8'd0, 1'b0, 1'b0, 1'b0);
    run_phase(8'd255, 1'b1, 1'b0, 1'b0);
    run_phase(RADIX_MAX + 8'd1, 1'b1, 1'b0, 1'b0);
    run_phase(RADIX_MIN - 8'd1, 1'b1, 1'b0, 1'b0);
    run_phase(CFG_W'($urandom_range(RADIX_MIN, RADIX_MAX)), 1'b1, 1'b0, 1'b0);
    run_phase(CFG_W'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
    if (expected_results.size() != 0) mismatches += expected_results.size();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
